[rtl/tcma_pkg.sv]
// Shared constants, types and control structs of the three-channel moving average.
`timescale 1ns / 1ps
package tcma_pkg;

  // Window length, channel count and field widths.
  localparam int Window   = 10;
  localparam int Channels = 3;
  localparam int SampleW  = 16;

  // An exact window sum needs the sample width plus the bits of the window length.
  localparam int SumW  = SampleW + $clog2(Window);
  localparam int ProdW = 2 * SumW;
  // A quotient magnitude reaches 32768, one bit beyond the sample width.
  localparam int QuotW = SampleW + 1;

  // Reciprocal of the window length scaled by 2^SumW, used for constant division.
  localparam logic [SumW-1:0] Recip = SumW'((64'd1 << SumW) / Window);

  // Bounds of a window sum, used by the checks.
  localparam logic signed [SumW-1:0] SumMin = SumW'(-32768 * Window);
  localparam logic signed [SumW-1:0] SumMax = SumW'(32767 * Window);

  typedef logic [Channels-1:0][SampleW-1:0] sample_t;
  typedef logic [SumW-1:0]                  sum_t;

  // Load strobes for the two divider stages.
  typedef struct packed {
    logic load_mul;
    logic load_out;
  } div_ctrl_t;

endpackage

[rtl/tcma_cell.sv]
// One window cell: holds one three-channel sample and hands it to its neighbor.
`timescale 1ns / 1ps
module tcma_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  tcma_pkg::sample_t sample_i,
  output tcma_pkg::sample_t sample_o
);
  import tcma_pkg::*;

  sample_t sample_q;
  sample_t sample_d;

  always_comb begin
    sample_d = shift_i ? sample_i : sample_q;
  end

  // The window starts out as all zeros.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

[rtl/tcma_div.sv]
// Two-stage signed division of a window sum by the window length, truncating toward zero.
`timescale 1ns / 1ps
module tcma_div (
  input  logic                       clk_i,
  input  tcma_pkg::div_ctrl_t        ctrl_i,
  input  tcma_pkg::sum_t             sum_i,
  output logic [tcma_pkg::SampleW-1:0] avg_o
);
  import tcma_pkg::*;

  logic             neg_q, neg_d;
  logic [SumW-1:0]  abs_q, abs_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [SampleW-1:0] avg_q, avg_d;

  logic [QuotW-1:0] q_est;
  logic [QuotW-1:0] q_fix;
  logic [SumW-1:0]  rem;

  // Stage one: magnitude and reciprocal product.
  always_comb begin
    neg_d  = sum_i[SumW-1];
    abs_d  = neg_d ? (~sum_i + SumW'(1)) : sum_i;
    prod_d = ProdW'(abs_d) * ProdW'(Recip);
  end

  // Stage two: the estimate is low by at most one, so one compare fixes it.
  // The back-multiplied estimate reaches a full window sum, so it is formed
  // at the sum width.
  always_comb begin
    q_est = QuotW'(prod_q[ProdW-1:SumW]);
    rem   = abs_q - SumW'(q_est) * SumW'(Window);
    q_fix = (rem >= SumW'(Window)) ? (q_est + QuotW'(1)) : q_est;
    avg_d = neg_q ? SampleW'(~q_fix + QuotW'(1)) : SampleW'(q_fix);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_mul) begin
      neg_q  <= neg_d;
      abs_q  <= abs_d;
      prod_q <= prod_d;
    end
    if (ctrl_i.load_out) begin
      avg_q <= avg_d;
    end
  end

  assign avg_o = avg_q;

endmodule

[rtl/three_channel_moving_average.sv]
// Top level of the three-channel boxcar moving average with a chain of window cells.
// An accepted item passes the running-sum register, the divider product register and the divider output register.
// Throughput: one item per cycle while the receiver keeps taking results, set by the running-sum update.
// The output divider is a two-stage pipeline: reciprocal multiply, then correction.
// Reset clears the window cells, running sums and all stage valid flags at once.
// After reset the early averages include the zeros still held in the window.
`timescale 1ns / 1ps
module three_channel_moving_average (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [15:0]         sample_ch0_i,
  input  logic signed [15:0]         sample_ch1_i,
  input  logic signed [15:0]         sample_ch2_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [15:0]         average_ch0_o,
  output logic signed [15:0]         average_ch1_o,
  output logic signed [15:0]         average_ch2_o
);
  import tcma_pkg::*;

  // The window is a shift chain of Window cells. Cell zero takes the newest
  // item and the last cell holds the oldest one, which drops out when the
  // next item is shifted in. This is the same as a ring with a write pointer,
  // since the slot that a ring overwrites is always its oldest.
  sample_t chain [Window+1];
  sample_t new_sample;
  logic    accept;

  assign new_sample = {sample_ch2_i, sample_ch1_i, sample_ch0_i};
  assign chain[0]   = new_sample;

  for (genvar k = 0; k < Window; k++) begin : g_cell
    tcma_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (accept),
      .sample_i (chain[k]),
      .sample_o (chain[k+1])
    );
  end

  // Pipeline flow control. Each stage can take new data when it is empty or
  // when the stage after it is moving, so an item can enter while a finished
  // result still waits at the output.
  logic v1_q, v1_d;
  logic v2_q, v2_d;
  logic v3_q, v3_d;
  logic rdy1, rdy2, rdy3;
  div_ctrl_t div_ctrl;

  always_comb begin
    rdy3 = !v3_q || out_ready_i;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    accept = in_valid_i && rdy1;
    v1_d = rdy1 ? in_valid_i : v1_q;
    v2_d = rdy2 ? v1_q : v2_q;
    v3_d = rdy3 ? v2_q : v3_q;
    div_ctrl.load_mul = rdy2 && v1_q;
    div_ctrl.load_out = rdy3 && v2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // Running sums: add the newest sample and take away the one leaving the
  // window. The sums are wide enough that they never wrap. The sum register
  // doubles as the payload of the first pipeline stage, because it only
  // changes when an item is accepted into that stage.
  logic [Channels-1:0][SumW-1:0] sum_q, sum_d;
  sample_t oldest;

  assign oldest = chain[Window];

  always_comb begin
    for (int c = 0; c < Channels; c++) begin
      sum_d[c] = sum_q[c];
      if (accept) begin
        sum_d[c] = sum_q[c]
                 + {{(SumW-SampleW){new_sample[c][SampleW-1]}}, new_sample[c]}
                 - {{(SumW-SampleW){oldest[c][SampleW-1]}}, oldest[c]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // One divider per channel; all three share the same stage strobes.
  logic [Channels-1:0][SampleW-1:0] avg;

  for (genvar c = 0; c < Channels; c++) begin : g_div
    tcma_div u_div (
      .clk_i  (clk_i),
      .ctrl_i (div_ctrl),
      .sum_i  (sum_q[c]),
      .avg_o  (avg[c])
    );
  end

  assign in_ready_o    = rdy1;
  assign out_valid_o   = v3_q;
  assign average_ch0_o = avg[0];
  assign average_ch1_o = avg[1];
  assign average_ch2_o = avg[2];

`ifndef SYNTHESIS
  // Input is held off only when every stage holds an item.
  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q))
    else $error("input stalled while a pipeline stage is empty");

  // An item in the first stage moves on whenever the next stage can take it.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && rdy2) |=> v2_q)
    else $error("item lost between sum stage and multiply stage");

  // The sums change only when an item is accepted.
  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(sum_q))
    else $error("running sums changed without an accepted item");

  // Each running sum stays within the range of a full window.
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($signed(sum_q[0]) >= SumMin) && ($signed(sum_q[0]) <= SumMax)
    && ($signed(sum_q[1]) >= SumMin) && ($signed(sum_q[1]) <= SumMax)
    && ($signed(sum_q[2]) >= SumMin) && ($signed(sum_q[2]) <= SumMax))
    else $error("running sum out of window range");
`endif

endmodule

[verif/three_channel_moving_average_tb.sv]
// Self-checking testbench for the three-channel moving average with random handshake stalls.
`timescale 1ns / 1ps
module three_channel_moving_average_tb;

  import tcma_pkg::*;

  // Run bounds. The cycle limit sits far above the slowest legal run, even
  // with every stall that the handshakes allow.
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 8;
  localparam int RandomItems = 1700;

  // Neither side idles inside this window of cycles, so the block also runs
  // for a long stretch at its full rate of one item per cycle.
  localparam int CalmStart = 1500;
  localparam int CalmEnd   = 2300;

  // The receiver stalls once for a long stretch, set by HoldoffCycles, after this many items.
  localparam int HoldoffAfter  = 400;
  localparam int HoldoffCycles = 120;

  // Kinds of readings used by the random part of the stimulus.
  typedef enum int {
    FullScale,
    RailValue,
    NearZero
  } reading_flavor_e;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Every input of the block starts at a known value.
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] sample_ch0_i = '0;
  logic signed [15:0] sample_ch1_i = '0;
  logic signed [15:0] sample_ch2_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic signed [15:0] average_ch0_o;
  logic signed [15:0] average_ch1_o;
  logic signed [15:0] average_ch2_o;

  // Items still to be offered, and averages still to be seen at the output.
  sample_t pending_samples_q[$];
  sample_t expected_averages_q[$];

  // The predictor's own copy of the window, its write pointer and the running sums.
  sample_t                 window_ring [Window];
  int unsigned             window_slot;
  logic signed [SumW-1:0]  window_sum  [Channels];

  int samples_accepted = 0;
  int error_count      = 0;
  int cycle_count      = 0;
  int holdoff_left     = 0;
  bit holdoff_done     = 1'b0;

  three_channel_moving_average i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_ch0_i  (sample_ch0_i),
    .sample_ch1_i  (sample_ch1_i),
    .sample_ch2_i  (sample_ch2_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .average_ch0_o (average_ch0_o),
    .average_ch1_o (average_ch1_o),
    .average_ch2_o (average_ch2_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Reset is held from time zero and released at a rising edge, once.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Pack three channel readings into one item, channel 0 in the low bits.
  function automatic sample_t make_sample(logic [15:0] c0, logic [15:0] c1, logic [15:0] c2);
    sample_t s;
    s[0] = c0;
    s[1] = c1;
    s[2] = c2;
    return s;
  endfunction

  function automatic void push_repeat(sample_t s, int count);
    for (int i = 0; i < count; i++) begin
      pending_samples_q.push_back(s);
    end
  endfunction

  function automatic logic [15:0] pick_reading(reading_flavor_e flavor);
    case (flavor)
      RailValue: begin
        case ($urandom_range(3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'hFFFF;
          default: return 16'h0000;
        endcase
      end
      // Small values around zero exercise truncation of negative quotients.
      NearZero: return 16'(int'($urandom_range(40)) - 20);
      default:  return 16'($urandom);
    endcase
  endfunction

  // Both sides idle at random with a probability of 31 percent, except in the calm window.
  function automatic bit idle_now();
    if (cycle_count >= CalmStart && cycle_count < CalmEnd) begin
      return 1'b0;
    end
    return $urandom_range(99) < 31;
  endfunction

  // Advance the predicted window by one item and return the three averages.
  // The oldest slot leaves the running sum as the new reading enters it, and
  // the division truncates toward zero as SystemVerilog's signed divide does.
  function automatic sample_t next_window_average(sample_t s);
    sample_t avg;
    int      quotient;
    for (int c = 0; c < Channels; c++) begin
      window_sum[c] = window_sum[c] + $signed(s[c]) - $signed(window_ring[window_slot][c]);
      quotient      = window_sum[c] / Window;
      avg[c]        = quotient[15:0];
    end
    window_ring[window_slot] = s;
    window_slot = (window_slot == Window - 1) ? 0 : window_slot + 1;
    return avg;
  endfunction

  // Stimulus. The directed part comes first, then random runs of items.
  initial begin : fill_stimulus
    int              run_length;
    int              pick;
    reading_flavor_e flavor;

    // The predictor starts from the cleared state that reset leaves.
    for (int i = 0; i < Window; i++) begin
      window_ring[i] = '0;
    end
    for (int c = 0; c < Channels; c++) begin
      window_sum[c] = '0;
    end
    window_slot = 0;

    // A full window at the rails: the sums reach their largest magnitudes, and
    // the early averages show the zeros still held in the partial window.
    push_repeat(make_sample(16'h7FFF, 16'h8000, 16'h0000), Window);
    // The opposite rails replace them slot by slot, crossing the sums through zero.
    push_repeat(make_sample(16'h8000, 16'h7FFF, 16'hFFFF), Window);
    // Small negative and positive readings check truncation toward zero.
    pending_samples_q.push_back(make_sample(-16'sd9, -16'sd19, 16'sd9));
    pending_samples_q.push_back(make_sample(-16'sd1, 16'sd1, -16'sd11));
    pending_samples_q.push_back(make_sample(-16'sd10, 16'sd10, 16'h8000));
    // Alternating bit patterns toggle every input bit.
    pending_samples_q.push_back(make_sample(16'h5555, 16'hAAAA, 16'h7FFF));
    pending_samples_q.push_back(make_sample(16'hAAAA, 16'h5555, 16'h0000));

    // Random runs of one flavor, each long enough at times to fill the window.
    for (int n = 0; n < RandomItems; n += run_length) begin
      run_length = $urandom_range(15, 1);
      pick       = $urandom_range(99);
      flavor     = (pick < 60) ? FullScale : (pick < 80) ? RailValue : NearZero;
      for (int i = 0; i < run_length; i++) begin
        pending_samples_q.push_back(make_sample(pick_reading(flavor), pick_reading(flavor),
                                                pick_reading(flavor)));
      end
    end
  end

  // Input driver. An accepted item goes through the predictor at the edge that
  // accepts it; a new item is offered only once the current one is taken, so
  // valid and the payload hold steady while the block stalls.
  always @(posedge clk_i or negedge rst_ni) begin : drive_samples
    sample_t next_sample;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_averages_q.push_back(
          next_window_average(make_sample(sample_ch0_i, sample_ch1_i, sample_ch2_i)));
        samples_accepted <= samples_accepted + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        // During the receiver's long stall the sender keeps offering, so the
        // pipeline fills and the block must push back on its input.
        if (pending_samples_q.size() != 0 && (holdoff_left != 0 || !idle_now())) begin
          next_sample  = pending_samples_q.pop_front();
          in_valid_i   <= 1'b1;
          sample_ch0_i <= next_sample[0];
          sample_ch1_i <= next_sample[1];
          sample_ch2_i <= next_sample[2];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output ready. It stalls at random, and once for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (!holdoff_done && samples_accepted >= HoldoffAfter) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HoldoffCycles;
      out_ready_i  <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready_i  <= 1'b0;
    end else begin
      out_ready_i <= !idle_now();
    end
  end

  // Output monitor. Each accepted result is checked against the oldest
  // expectation, channel by channel.
  always @(posedge clk_i) begin : check_averages
    sample_t want;
    sample_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = make_sample(average_ch0_o, average_ch1_o, average_ch2_o);
      if (expected_averages_q.size() == 0) begin
        $error("result with no item outstanding: %0d %0d %0d",
               average_ch0_o, average_ch1_o, average_ch2_o);
        error_count++;
      end else begin
        want = expected_averages_q.pop_front();
        for (int c = 0; c < Channels; c++) begin
          if (got[c] !== want[c]) begin
            $error("average_ch%0d: expected %0d, actual %0d",
                   c, $signed(want[c]), $signed(got[c]));
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog. A hang or a result that never arrives ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // End of run: every item offered and accepted, every expected average seen,
  // then a further drain so that a stray extra result is still caught.
  initial begin
    @(posedge rst_ni);
    while (pending_samples_q.size() != 0 || in_valid_i || expected_averages_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
